FILE: hw/rtl/dtwsl_pkg.sv
package dtwsl_pkg;

    localparam int unsigned REF_W   = 28;
    localparam int unsigned FREQ_W  = 27;
    localparam int unsigned PHASE_W = 5;
    localparam int unsigned TW_W    = 32;
    localparam int unsigned PB_W    = 8;
    localparam int unsigned IDX_W   = 6;
    localparam int unsigned CNT_W   = 5;

    localparam logic [REF_W-1:0] REF_RESET = 28'd125000000;
    localparam logic [PB_W-1:0]  PWRDN_BYTE = 8'h04;

    localparam logic [1:0] MODE_SET  = 2'd0;
    localparam logic [1:0] MODE_PWRDN = 2'd1;
    localparam logic [1:0] MODE_WAKE = 2'd2;
    localparam logic [1:0] MODE_INIT = 2'd3;

    // Index of the final event of each sequence.
    localparam logic [IDX_W-1:0] LAST_SEND  = 6'd40;
    localparam logic [IDX_W-1:0] LAST_PWRDN = 6'd9;
    localparam logic [IDX_W-1:0] LAST_INIT  = 6'd2;

    localparam logic [CNT_W-1:0] DIV_LAST = 5'd31;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic data_bit;
        logic shift_clock;
        logic latch_pulse;
        logic reset_pulse;
        logic last;
    } t_event;

endpackage

FILE: hw/rtl/dtwsl_if.sv
interface dtwsl_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [26:0] freq_hz;
    logic [4:0]  phase_step;

    modport source (output valid, mode, freq_hz, phase_step, input ready);
    modport sink (input valid, mode, freq_hz, phase_step, output ready);
endinterface

interface dtwsl_out_if;
    logic valid;
    logic ready;
    logic data_bit;
    logic shift_clock;
    logic latch_pulse;
    logic reset_pulse;
    logic last;

    modport source (output valid, data_bit, shift_clock, latch_pulse, reset_pulse, last,
                    input ready);
    modport sink (input valid, data_bit, shift_clock, latch_pulse, reset_pulse, last,
                  output ready);
endinterface

FILE: hw/rtl/dds_tuning_word_serial_loader.sv
// A set-frequency item is accepted, runs the restoring divider and then gives 41 pin
// events, one per cycle when the sink is always ready. One item is in work at a time.
// A saturating set-frequency item skips the divider and behaves like a wake-up.
// Wake-up gives 41 events, power-down 10 and initialize 3. For these the state register
// enters the emit state on acceptance; events go out through the output register.
// Reset (synchronous, active low) clears the store and loads the reference 125000000.
module dds_tuning_word_serial_loader
    import dtwsl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [REF_W-1:0]   i_cfg_data,
    dtwsl_in_if.sink           i_in,
    dtwsl_out_if.source        o_out
);

    t_state              r_state, n_state;
    logic [REF_W-1:0]    r_ref;
    logic [TW_W-1:0]     r_tuning_word, n_tuning_word;
    logic [PB_W-1:0]     r_phase_byte, n_phase_byte;
    logic [1:0]          r_mode, n_mode;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [REF_W-1:0]    r_rem, n_rem;
    logic [TW_W-1:0]     r_quo, n_quo;
    logic                r_out_valid, n_out_valid;
    t_event              r_out, n_out;

    logic                in_acc;
    logic                saturate;
    logic [REF_W:0]      rem2;
    logic                ge;
    logic [REF_W:0]      rem_sub;
    logic [TW_W+PB_W-1:0] word40;
    logic [IDX_W-1:0]    last_idx;
    t_event              evt;
    logic [2:0]          pd_bit;

    assign in_acc   = i_in.valid && i_in.ready;
    assign saturate = (r_ref == '0) || ({1'b0, i_in.freq_hz} >= r_ref);

    // One restoring step of (freq << 32) / ref.
    assign rem2    = {r_rem, 1'b0};
    assign ge      = rem2 >= {1'b0, r_ref};
    assign rem_sub = rem2 - {1'b0, r_ref};

    assign word40 = {r_phase_byte, r_tuning_word};
    assign pd_bit = 3'(r_idx - 6'd1);

    always_comb begin
        evt      = '0;
        last_idx = LAST_INIT;
        case (r_mode) inside
            MODE_SET, MODE_WAKE: begin
                last_idx = LAST_SEND;
                if (r_idx == LAST_SEND) begin
                    evt.latch_pulse = 1'b1;
                end else begin
                    evt.data_bit    = word40[r_idx];
                    evt.shift_clock = 1'b1;
                end
            end
            MODE_PWRDN: begin
                last_idx = LAST_PWRDN;
                if (r_idx == '0 || r_idx == LAST_PWRDN) begin
                    evt.latch_pulse = 1'b1;
                end else begin
                    evt.data_bit    = PWRDN_BYTE[pd_bit];
                    evt.shift_clock = 1'b1;
                end
            end
            default: begin
                last_idx = LAST_INIT;
                if (r_idx == '0) begin
                    evt.reset_pulse = 1'b1;
                end else if (r_idx == LAST_INIT) begin
                    evt.latch_pulse = 1'b1;
                end else begin
                    evt.shift_clock = 1'b1;
                end
            end
        endcase
        evt.last = (r_idx == last_idx);
    end

    always_comb begin
        n_state       = r_state;
        n_tuning_word = r_tuning_word;
        n_phase_byte  = r_phase_byte;
        n_mode        = r_mode;
        n_idx         = r_idx;
        n_cnt         = r_cnt;
        n_rem         = r_rem;
        n_quo         = r_quo;
        n_out_valid   = r_out_valid;
        n_out         = r_out;

        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_mode  = i_in.mode;
                    n_idx   = '0;
                    n_cnt   = '0;
                    n_state = ST_EMIT;
                    case (i_in.mode)
                        MODE_SET: begin
                            n_phase_byte = {i_in.phase_step, 3'b000};
                            n_rem        = {1'b0, i_in.freq_hz};
                            n_quo        = '0;
                            if (saturate) begin
                                n_tuning_word = '1;
                            end else begin
                                n_state = ST_DIV;
                            end
                        end
                        MODE_INIT: begin
                            n_tuning_word = '0;
                            n_phase_byte  = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_DIV: begin
                n_rem = ge ? rem_sub[REF_W-1:0] : rem2[REF_W-1:0];
                n_quo = {r_quo[TW_W-2:0], ge};
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == DIV_LAST) begin
                    n_tuning_word = {r_quo[TW_W-2:0], ge};
                    n_state       = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out       = evt;
                    n_idx       = r_idx + 6'd1;
                    if (evt.last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_tuning_word <= '0;
            r_phase_byte  <= '0;
            r_out_valid   <= 1'b0;
            r_mode        <= MODE_SET;
            r_idx         <= '0;
            r_cnt         <= '0;
        end else begin
            r_state       <= n_state;
            r_tuning_word <= n_tuning_word;
            r_phase_byte  <= n_phase_byte;
            r_out_valid   <= n_out_valid;
            r_mode        <= n_mode;
            r_idx         <= n_idx;
            r_cnt         <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref <= REF_RESET;
        end else if (i_cfg_we) begin
            r_ref <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_out <= n_out;
    end

    assign i_in.ready        = (r_state == ST_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.data_bit    = r_out.data_bit;
    assign o_out.shift_clock = r_out.shift_clock;
    assign o_out.latch_pulse = r_out.latch_pulse;
    assign o_out.reset_pulse = r_out.reset_pulse;
    assign o_out.last        = r_out.last;

    a_div_to_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && r_cnt == DIV_LAST) |=> (r_state == ST_EMIT && r_idx == '0))
        else $error("divider did not hand over to the event sequencer");

    a_hold_while_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> (o_out.valid && $stable(r_out)))
        else $error("pending event changed before the sink took it");

    a_init_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.mode == MODE_INIT) |=> (r_tuning_word == '0 && r_phase_byte == '0))
        else $error("initialize did not clear the store");

    a_set_divides: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.mode == MODE_SET && !saturate) |=> (r_state == ST_DIV))
        else $error("set-frequency item did not start the divider");

endmodule
